// ----- design/klg_pkg.sv -----
package klg_pkg;

   // Register file indexes
   typedef enum logic [1:0] {
      CSR_SAMPLE_RATE     = 2'd0,
      CSR_CLOSED_QUOTIENT = 2'd1,
      CSR_AMPLITUDE       = 2'd2,
      CSR_PERIOD_DIVISOR  = 2'd3
   } klg_csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // Reset values of the registers
   localparam logic [16:0] SAMPLE_RATE_RST     = 17'd32000;
   localparam logic [15:0] CLOSED_QUOTIENT_RST = 16'd9830;
   localparam logic [15:0] AMPLITUDE_RST       = 16'd4096;
   localparam logic [11:0] PERIOD_DIVISOR_RST  = 12'd320;

   localparam int FREQ_W   = 12;
   localparam int SAMPLE_W = 16;

   // Datapath widths
   localparam int OQ_W    = 17;   // 1.0 - CQ in Q0.16, up to 65536
   localparam int R_W     = 34;   // fs * OQ
   localparam int D_W     = 29;   // divisor * OQ
   localparam int U_W     = 24;   // normalized phase, Q0.24
   localparam int MAG_W   = 25;   // |2u - 3u^2|, at most 1.0 in Q0.24
   localparam int POLY_W  = 28;
   localparam int M_W     = 41;   // |poly| * amp
   localparam int A_W     = 47;   // |poly| * amp * 54
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Shared serial divider
   localparam int DIV_W  = 37;
   localparam int QUOT_W = 24;
   localparam int Q2_W   = 17;    // quotient bits of the scaling division
   localparam int CNT_W  = 5;
   localparam int DIV1_STEPS = 24;
   localparam int DIV2_STEPS = 17;

   // 27 * 2, the Q factor of the KLGLOTT88 amplitude term
   localparam int SCALE_K = 54;

   typedef struct packed {
      logic [16:0] sample_rate;
      logic [15:0] closed_quotient;
      logic [15:0] amplitude;
      logic [11:0] period_divisor;
   } klg_cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_P,
      OP_MUL_R,
      OP_MUL_D,
      OP_CHECK,
      OP_DIV_STEP,
      OP_SQUARE,
      OP_POLY,
      OP_MUL_AMP,
      OP_SCALE,
      OP_LOAD2,
      OP_SAT,
      OP_MUL_NEXT,
      OP_UPDATE
   } klg_op_type;

   typedef struct packed {
      klg_op_type op;
      logic       emit;
   } klg_cmd_type;

   typedef struct packed {
      logic open;        // open phase for the current item
      logic out_stall;   // result register full and not taken
   } klg_stat_type;

endpackage

// ----- design/klg_req_if.sv -----
interface klg_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] frequency;

   modport source (output valid, output frequency, input ready);
   modport sink   (input valid, input frequency, output ready);
endinterface

// ----- design/klg_rsp_if.sv -----
interface klg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- design/klg_div.sv -----
// Restoring divider, one quotient bit per step.
// rem_init must be below den_init; bits_init feeds numerator bits MSB first.
module klg_div (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic [klg_pkg::DIV_W-1:0]   rem_init,
   input  logic [klg_pkg::QUOT_W-1:0]  bits_init,
   input  logic [klg_pkg::DIV_W-1:0]   den_init,
   output logic [klg_pkg::QUOT_W-1:0]  quot
);

   localparam int DW = klg_pkg::DIV_W;
   localparam int QW = klg_pkg::QUOT_W;

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] bits_ff, bits_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, bits_ff[QW-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (load) begin
         rem_in  = rem_init;
         bits_in = bits_init;
         quot_in = '0;
         den_in  = den_init;
      end else if (step) begin
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         bits_in = {bits_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign quot = quot_ff;

endmodule

// ----- design/klg_dp.sv -----
// Datapath: one shared multiplier, a constant times-54 product, the serial divider, phase counter.
module klg_dp #(
   parameter int PHASE_BITS = 17
) (
   input  logic                           clock,
   input  logic                           reset,
   input  klg_pkg::klg_op_type            op,
   input  klg_pkg::klg_cfg_type           cfg,
   input  logic [klg_pkg::FREQ_W-1:0]     frequency,
   output logic                           open,
   output logic [klg_pkg::SAMPLE_W-1:0]   sample
);

   localparam int PW  = PHASE_BITS + klg_pkg::FREQ_W;   // n * f
   localparam int XW  = PW + 16;                        // n * f * 65536
   localparam int AW  = klg_pkg::MUL_A_W;
   localparam int BW  = klg_pkg::MUL_B_W;
   localparam int PRW = klg_pkg::PROD_W;
   localparam int DW  = klg_pkg::DIV_W;
   localparam int QW  = klg_pkg::QUOT_W;
   localparam int RW  = klg_pkg::R_W;
   localparam int DDW = klg_pkg::D_W;
   localparam int UW  = klg_pkg::U_W;
   localparam int MW  = klg_pkg::MAG_W;
   localparam int YW  = klg_pkg::POLY_W;
   localparam int M1W = klg_pkg::M_W;
   localparam int A1W = klg_pkg::A_W;
   localparam int Q2W = klg_pkg::Q2_W;
   localparam int SW  = klg_pkg::SAMPLE_W;

   logic [klg_pkg::FREQ_W-1:0] f_ff, f_in;
   logic [PHASE_BITS-1:0]      n_ff, n_in;
   logic [PHASE_BITS-1:0]      nxt_ff, nxt_in;
   logic [PW-1:0]              p_ff, p_in;
   logic [RW-1:0]              r_ff, r_in;
   logic [DDW-1:0]             dd_ff, dd_in;
   logic [UW-1:0]              u2_ff, u2_in;
   logic [MW-1:0]              mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [M1W-1:0]             m_ff, m_in;
   logic [A1W-1:0]             a_ff, a_in;
   logic                       ovf_ff, ovf_in;
   logic [SW-1:0]              sample_ff, sample_in;

   logic [klg_pkg::OQ_W-1:0]   oq;
   logic [11:0]                d_eff;
   logic [PHASE_BITS-1:0]      nxt;
   logic [AW-1:0]              mul_a;
   logic [BW-1:0]              mul_b;
   logic [PRW-1:0]             prod;
   logic [XW-1:0]              x_full;
   logic [DW-1:0]              den2;
   logic [UW-1:0]              u;
   logic [UW+1:0]              three_u2;
   logic [YW-1:0]              poly;
   logic [YW-1:0]              poly_abs;
   logic [Q2W-1:0]             q;
   logic [SW-1:0]              s;
   logic                       div_load;
   logic                       div_step;
   logic [DW-1:0]              div_rem_init;
   logic [QW-1:0]              div_bits_init;
   logic [DW-1:0]              div_den_init;
   logic [QW-1:0]              div_quot;

   klg_div u_div (
      .clock     (clock),
      .load      (div_load),
      .step      (div_step),
      .rem_init  (div_rem_init),
      .bits_init (div_bits_init),
      .den_init  (div_den_init),
      .quot      (div_quot)
   );

   always_comb begin
      oq     = 17'h10000 - {1'b0, cfg.closed_quotient};
      d_eff  = (cfg.period_divisor == 12'd0) ? 12'd1 : cfg.period_divisor;
      nxt    = PHASE_BITS'(n_ff + 1'b1);
      x_full = {p_ff, 16'h0000};
      open   = x_full < XW'(r_ff);
      den2   = {dd_ff, 8'h00};
      u      = div_quot;

      // 2u - 3u^2, then sign and magnitude
      three_u2 = {2'b00, u2_ff} + {1'b0, u2_ff, 1'b0};
      poly     = {3'b000, u, 1'b0} - {2'b00, three_u2};
      poly_abs = poly[YW-1] ? (~poly + 1'b1) : poly;

      // Saturation of the scaled quotient
      q = div_quot[Q2W-1:0];
      if (neg_ff) begin
         if (ovf_ff || q > 17'd32768) s = 16'h8000;
         else                         s = SW'(~q + 1'b1);
      end else begin
         if (ovf_ff || q > 17'd32767) s = 16'h7FFF;
         else                         s = q[SW-1:0];
      end

      // Shared multiplier operand select
      case (op)
         klg_pkg::OP_MUL_P: begin
            mul_a = AW'(n_ff);
            mul_b = BW'(f_ff);
         end
         klg_pkg::OP_MUL_R: begin
            mul_a = AW'(cfg.sample_rate);
            mul_b = BW'(oq);
         end
         klg_pkg::OP_MUL_D: begin
            mul_a = AW'(d_eff);
            mul_b = BW'(oq);
         end
         klg_pkg::OP_SQUARE: begin
            mul_a = AW'(u);
            mul_b = u;
         end
         klg_pkg::OP_MUL_AMP: begin
            mul_a = mag_ff;
            mul_b = BW'(cfg.amplitude);
         end
         klg_pkg::OP_MUL_NEXT: begin
            mul_a = AW'(nxt);
            mul_b = BW'(f_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = PRW'(mul_a) * PRW'(mul_b);

      f_in          = f_ff;
      n_in          = n_ff;
      nxt_in        = nxt_ff;
      p_in          = p_ff;
      r_in          = r_ff;
      dd_in         = dd_ff;
      u2_in         = u2_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      m_in          = m_ff;
      a_in          = a_ff;
      ovf_in        = ovf_ff;
      sample_in     = sample_ff;
      div_load      = 1'b0;
      div_step      = 1'b0;
      div_rem_init  = x_full[DW-1:0];
      div_bits_init = '0;
      div_den_init  = DW'(r_ff);

      case (op)
         klg_pkg::OP_LOAD:     f_in = frequency;
         klg_pkg::OP_MUL_P:    p_in = prod[PW-1:0];
         klg_pkg::OP_MUL_R:    r_in = prod[RW-1:0];
         klg_pkg::OP_MUL_D:    dd_in = prod[DDW-1:0];
         klg_pkg::OP_CHECK: begin
            // fraction (n*f*65536)/(fs*OQ), 24 bits
            div_load = 1'b1;
            if (!open) sample_in = '0;
         end
         klg_pkg::OP_DIV_STEP: div_step = 1'b1;
         klg_pkg::OP_SQUARE:   u2_in = prod[2*UW-1:UW];
         klg_pkg::OP_POLY: begin
            mag_in = poly_abs[MW-1:0];
            neg_in = poly[YW-1];
         end
         klg_pkg::OP_MUL_AMP:  m_in = prod[M1W-1:0];
         klg_pkg::OP_SCALE:    a_in = A1W'(m_ff) * A1W'(klg_pkg::SCALE_K);
         klg_pkg::OP_LOAD2: begin
            // quotient above 17 bits saturates in any case
            ovf_in        = DW'(a_ff[A1W-1:Q2W]) >= den2;
            div_load      = 1'b1;
            div_rem_init  = DW'(a_ff[A1W-1:Q2W]);
            div_bits_init = {a_ff[Q2W-1:0], {(QW-Q2W){1'b0}}};
            div_den_init  = den2;
         end
         klg_pkg::OP_SAT:      sample_in = {s[SW-4:0], 3'b000};
         klg_pkg::OP_MUL_NEXT: begin
            p_in   = prod[PW-1:0];
            nxt_in = nxt;
         end
         klg_pkg::OP_UPDATE:
            n_in = (p_ff >= PW'(cfg.sample_rate)) ? '0 : nxt_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      f_ff      <= f_in;
      nxt_ff    <= nxt_in;
      p_ff      <= p_in;
      r_ff      <= r_in;
      dd_ff     <= dd_in;
      u2_ff     <= u2_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      m_ff      <= m_in;
      a_ff      <= a_in;
      ovf_ff    <= ovf_in;
      sample_ff <= sample_in;
   end

   assign sample = sample_ff;

endmodule

// ----- design/klg_ctrl.sv -----
// Sequencer for one item at a time.
module klg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  klg_pkg::klg_stat_type  stat,
   output klg_pkg::klg_cmd_type   cmd
);

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_MUL_P    = 16'h0002,
      ST_MUL_R    = 16'h0004,
      ST_MUL_D    = 16'h0008,
      ST_CHECK    = 16'h0010,
      ST_DIV1     = 16'h0020,
      ST_SQUARE   = 16'h0040,
      ST_POLY     = 16'h0080,
      ST_MUL_AMP  = 16'h0100,
      ST_SCALE    = 16'h0200,
      ST_LOAD2    = 16'h0400,
      ST_DIV2     = 16'h0800,
      ST_SAT      = 16'h1000,
      ST_MUL_NEXT = 16'h2000,
      ST_UPDATE   = 16'h4000,
      ST_DONE     = 16'h8000
   } klg_state_type;

   localparam int CW = klg_pkg::CNT_W;

   klg_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd.op    = klg_pkg::OP_NONE;
      cmd.emit  = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = klg_pkg::OP_LOAD;
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.op   = klg_pkg::OP_MUL_P;
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            cmd.op   = klg_pkg::OP_MUL_R;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.op   = klg_pkg::OP_MUL_D;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.op = klg_pkg::OP_CHECK;
            if (stat.open) begin
               cnt_in   = CW'(klg_pkg::DIV1_STEPS - 1);
               state_in = ST_DIV1;
            end else begin
               state_in = ST_MUL_NEXT;
            end
         end
         ST_DIV1: begin
            cmd.op = klg_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.op   = klg_pkg::OP_SQUARE;
            state_in = ST_POLY;
         end
         ST_POLY: begin
            cmd.op   = klg_pkg::OP_POLY;
            state_in = ST_MUL_AMP;
         end
         ST_MUL_AMP: begin
            cmd.op   = klg_pkg::OP_MUL_AMP;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = klg_pkg::OP_SCALE;
            state_in = ST_LOAD2;
         end
         ST_LOAD2: begin
            cmd.op   = klg_pkg::OP_LOAD2;
            cnt_in   = CW'(klg_pkg::DIV2_STEPS - 1);
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.op = klg_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.op   = klg_pkg::OP_SAT;
            state_in = ST_MUL_NEXT;
         end
         ST_MUL_NEXT: begin
            cmd.op   = klg_pkg::OP_MUL_NEXT;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op   = klg_pkg::OP_UPDATE;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.out_stall) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- design/klglott88_glottal_source_core.sv -----
// KLGLOTT88 glottal flow derivative source. Each req item is one audio tick
// carrying the pitch in Hz; each produces exactly one rsp item, the 16-bit
// derivative sample (scaled by 32768, saturated, then times eight with wrap).
// A phase counter of PHASE_BITS bits (12..24) advances once per item and
// clears when it reaches fs/f. Items are worked one at a time: an open-phase
// tick steps the serial restoring divider twice (24 steps for the normalized
// phase, 17 for the amplitude scaling), a closed-phase tick not at all; every
// tick uses the shared multiplier. The result sits in an output register,
// so the next tick is accepted while it waits to be taken. Registers
// (0 sample_rate, 1 closed_quotient, 2 amplitude, 3 period_divisor) are
// written through csr_we/csr_index/csr_wdata; the user must write them only
// while idle, the block itself does not enforce it. A period_divisor of
// zero acts as one.
module klglott88_glottal_source_core #(
   parameter int PHASE_BITS = 17
) (
   input  logic                                 clock,
   input  logic                                 reset,
   klg_req_if.sink                              req_chan,
   klg_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [klg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [klg_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   klg_pkg::klg_cfg_type            cfg_ff, cfg_in;
   klg_pkg::klg_cmd_type            cmd;
   klg_pkg::klg_stat_type           stat;
   logic                            dp_open;
   logic [klg_pkg::SAMPLE_W-1:0]    dp_sample;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [klg_pkg::SAMPLE_W-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                            req_ready;

   // Register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (klg_pkg::klg_csr_index_type'(csr_index))
            klg_pkg::CSR_SAMPLE_RATE:     cfg_in.sample_rate     = csr_wdata;
            klg_pkg::CSR_CLOSED_QUOTIENT: cfg_in.closed_quotient = csr_wdata[15:0];
            klg_pkg::CSR_AMPLITUDE:       cfg_in.amplitude       = csr_wdata[15:0];
            klg_pkg::CSR_PERIOD_DIVISOR:  cfg_in.period_divisor  = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Output register: freed when taken, loaded when the sequencer finishes
   always_comb begin
      stat.open      = dp_open;
      stat.out_stall = rsp_valid_ff && !rsp_chan.ready;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in  = rsp_sample_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = dp_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_rate     <= klg_pkg::SAMPLE_RATE_RST;
         cfg_ff.closed_quotient <= klg_pkg::CLOSED_QUOTIENT_RST;
         cfg_ff.amplitude       <= klg_pkg::AMPLITUDE_RST;
         cfg_ff.period_divisor  <= klg_pkg::PERIOD_DIVISOR_RST;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
   end

   klg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   klg_dp #(
      .PHASE_BITS (PHASE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (cmd.op),
      .cfg       (cfg_ff),
      .frequency (req_chan.frequency),
      .open      (dp_open),
      .sample    (dp_sample)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.sample = rsp_sample_ff;

   // One item in flight: no new accept right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("item accepted while previous one in progress");

   // A finished item never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_chan.ready))
      else $error("result register overwritten");

   // Times-eight scaling leaves the low three bits clear
   a_times_eight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff[2:0] == 3'b000)
      else $error("sample not a multiple of eight");

endmodule
